// ----- src/ihs_pkg.sv -----
// Shared types and constants for the integer hypotenuse block.
// No dependencies; used by ihs_root, integer_hypotenuse_sqrt and the testbench.
package ihs_pkg;

    // Width of the result field and the value a too-wide root saturates to.
    localparam int unsigned OUT_WIDTH = 16;
    localparam logic [OUT_WIDTH-1:0] OUT_MAX = {OUT_WIDTH{1'b1}};

    // Status the root unit reports to the sequencer in the top level.
    typedef struct packed {
        logic busy;
        logic done;
    } root_stat_t;

endpackage

// ----- src/ihs_root.sv -----
// Iterative restoring square-root unit: one root bit per clock cycle.
// Depends on ihs_pkg for the status struct.
module ihs_root #(
    parameter int unsigned LEG_WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [2*LEG_WIDTH-1:0]   radicand,
    output logic [LEG_WIDTH-1:0]     root,
    output ihs_pkg::root_stat_t      stat
);

    localparam int unsigned RAD_W = 2 * LEG_WIDTH;
    localparam int unsigned REM_W = LEG_WIDTH + 2;
    localparam int unsigned CNT_W = $clog2(LEG_WIDTH + 1);

    logic [RAD_W-1:0]     x_reg,   x_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [LEG_WIDTH-1:0] q_reg,   q_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 done_reg, done_next;

    logic [REM_W-1:0] rem_shift;
    logic [REM_W-1:0] trial;
    logic             fits;

    // Bring down the next two radicand bits and test the trial divisor 4q+1.
    assign rem_shift = {rem_reg[LEG_WIDTH-1:0], x_reg[RAD_W-1 -: 2]};
    assign trial     = {q_reg, 2'b01};
    assign fits      = (rem_shift >= trial);

    always_comb
    begin
        x_next    = x_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            x_next   = radicand;
            rem_next = '0;
            q_next   = '0;
            cnt_next = CNT_W'(LEG_WIDTH);
        end
        else if (cnt_reg != '0)
        begin
            x_next    = {x_reg[RAD_W-3:0], 2'b00};
            rem_next  = fits ? (rem_shift - trial) : rem_shift;
            q_next    = {q_reg[LEG_WIDTH-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign root      = q_reg;
    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;

endmodule

// ----- src/integer_hypotenuse_sqrt.sv -----
// Integer hypotenuse: floor(sqrt(side_a^2 + side_b^2)) of two signed legs.
// Depends on ihs_pkg and ihs_root.
//
// One input beat is taken, its leg magnitudes are formed exactly (the most
// negative leg counts as 2^(LEG_WIDTH-1)), and a single shared multiplier
// squares them one after the other, leg a and then leg b. The exact sum of
// squares then goes to a restoring square-root unit that produces one root
// bit per cycle. in_ready is high only while the sequencer is idle, but a
// finished result sits in an output register, so the next input beat is
// taken while the previous result still waits for out_ready. When LEG_WIDTH
// exceeds 16 the root can be wider than the result field and is then
// saturated to 65535. Input bits are taken only at LEG_WIDTH. The block
// holds no state between items and has no configuration.
module integer_hypotenuse_sqrt #(
    parameter int unsigned LEG_WIDTH = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [LEG_WIDTH-1:0]          side_a,
    input  logic signed [LEG_WIDTH-1:0]          side_b,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [ihs_pkg::OUT_WIDTH-1:0]        hypotenuse
);

    localparam int unsigned PROD_W = 2 * LEG_WIDTH;
    localparam int unsigned MAX_W  = (LEG_WIDTH > ihs_pkg::OUT_WIDTH) ?
                                     LEG_WIDTH : ihs_pkg::OUT_WIDTH;

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SQA  = 3'd1;
    localparam logic [2:0] S_SQB  = 3'd2;
    localparam logic [2:0] S_ADD  = 3'd3;
    localparam logic [2:0] S_ROOT = 3'd4;
    localparam logic [2:0] S_WAIT = 3'd5;

    logic [2:0]                      state_reg, state_next;
    logic [LEG_WIDTH-1:0]            mag_a_reg, mag_a_next;
    logic [LEG_WIDTH-1:0]            mag_b_reg, mag_b_next;
    logic [PROD_W-1:0]               prod_reg,  prod_next;
    logic [PROD_W-1:0]               sum_reg,   sum_next;
    logic                            out_valid_reg, out_valid_next;
    logic [ihs_pkg::OUT_WIDTH-1:0]   hyp_reg, hyp_next;

    logic                            in_fire;
    logic                            out_free;
    logic                            load_out;
    logic [LEG_WIDTH-1:0]            a_bits, b_bits;
    logic [LEG_WIDTH-1:0]            mul_op;
    logic [PROD_W-1:0]               mul_prod;
    logic                            root_start;
    logic [PROD_W-1:0]               radicand;
    logic [LEG_WIDTH-1:0]            root;
    logic [MAX_W-1:0]                root_ext;
    logic [ihs_pkg::OUT_WIDTH-1:0]   root_sat;
    ihs_pkg::root_stat_t             root_stat;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    // Two's complement magnitude; the most negative leg wraps to 2^(LEG_WIDTH-1),
    // which is its true magnitude as an unsigned value.
    assign a_bits = $unsigned(side_a);
    assign b_bits = $unsigned(side_b);

    // The one multiplier squares leg a, then leg b, on consecutive cycles.
    assign mul_op   = (state_reg == S_SQB) ? mag_b_reg : mag_a_reg;
    assign mul_prod = PROD_W'(mul_op) * PROD_W'(mul_op);

    // Both squares are registered before the add, which feeds the root unit.
    assign root_start = (state_reg == S_ADD);
    assign radicand   = sum_reg + prod_reg;

    ihs_root #(
        .LEG_WIDTH (LEG_WIDTH)
    ) u_root (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (radicand),
        .root     (root),
        .stat     (root_stat)
    );

    // Saturate a root that does not fit the result field.
    assign root_ext = MAX_W'(root);
    assign root_sat = (root_ext > MAX_W'(ihs_pkg::OUT_MAX)) ?
                      ihs_pkg::OUT_MAX : root_ext[ihs_pkg::OUT_WIDTH-1:0];

    always_comb
    begin
        state_next = state_reg;
        mag_a_next = mag_a_reg;
        mag_b_next = mag_b_reg;
        prod_next  = prod_reg;
        sum_next   = sum_reg;
        load_out   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    mag_a_next = a_bits[LEG_WIDTH-1] ? (~a_bits + 1'b1) : a_bits;
                    mag_b_next = b_bits[LEG_WIDTH-1] ? (~b_bits + 1'b1) : b_bits;
                    state_next = S_SQA;
                end
            end
            S_SQA:
            begin
                prod_next  = mul_prod;
                state_next = S_SQB;
            end
            S_SQB:
            begin
                sum_next   = prod_reg;
                prod_next  = mul_prod;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                if (root_stat.done)
                begin
                    if (out_free)
                    begin
                        load_out   = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_WAIT;
                    end
                end
            end
            S_WAIT:
            begin
                // The root unit holds its result until the next start.
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        hyp_next       = hyp_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            hyp_next       = root_sat;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_a_reg <= mag_a_next;
        mag_b_reg <= mag_b_next;
        prod_reg  <= prod_next;
        sum_reg   <= sum_next;
        hyp_reg   <= hyp_next;
    end

    assign out_valid  = out_valid_reg;
    assign hypotenuse = hyp_reg;

    // The root unit reports completion only while the sequencer waits on it.
    assert property (@(posedge clk) disable iff (!rst_n)
        root_stat.done |-> (state_reg == S_ROOT))
        else $error("root done outside the root state");

    // A new beat is never taken while the root unit is still iterating.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !root_stat.busy)
        else $error("input ready while root unit busy");

    // An accepted beat always starts the squaring sequence.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == S_SQA))
        else $error("accepted beat did not start squaring");

endmodule

// ----- tb/sv/hypot_checker.sv -----
// Checker for the integer hypotenuse block: watches the input and result
// channels, predicts each root and compares. Depends on ihs_pkg.
module hypot_checker #(
    parameter int unsigned LEG_WIDTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic signed [LEG_WIDTH-1:0]     side_a,
    input  logic signed [LEG_WIDTH-1:0]     side_b,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [ihs_pkg::OUT_WIDTH-1:0]   hypotenuse,
    output int                              fail_count,
    output int                              pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [LEG_WIDTH-1:0]   leg_a;
        logic signed [LEG_WIDTH-1:0]   leg_b;
        logic [ihs_pkg::OUT_WIDTH-1:0] root;
    } root_entry_t;

    root_entry_t pending_roots[$];

    // Exact magnitude of a two's complement leg, one bit wider than the leg.
    function automatic logic [63:0] leg_magnitude(input logic [LEG_WIDTH-1:0] leg);
        logic [LEG_WIDTH:0] mag;
        if (leg[LEG_WIDTH-1])
            mag = {1'b0, ~leg} + 1'b1;
        else
            mag = {1'b0, leg};
        return 64'(mag);
    endfunction

    // Floor square root of the exact sum of squares, found bit by bit from
    // the top, then saturated to the result field.
    function automatic logic [ihs_pkg::OUT_WIDTH-1:0] hypot_floor(
        input logic [LEG_WIDTH-1:0] leg_a,
        input logic [LEG_WIDTH-1:0] leg_b
    );
        logic [63:0] mag_a;
        logic [63:0] mag_b;
        logic [63:0] sum_sq;
        logic [63:0] root;
        logic [63:0] trial;
        mag_a = leg_magnitude(leg_a);
        mag_b = leg_magnitude(leg_b);
        sum_sq = mag_a * mag_a + mag_b * mag_b;
        root = '0;
        for (int i = 31; i >= 0; i--)
        begin
            trial = root | (64'd1 << i);
            if (trial * trial <= sum_sq)
                root = trial;
        end
        if (root > 64'(ihs_pkg::OUT_MAX))
            root = 64'(ihs_pkg::OUT_MAX);
        return root[ihs_pkg::OUT_WIDTH-1:0];
    endfunction

    initial
    begin
        fail_count = 0;
        pending_count = 0;
    end

    always @(posedge clk)
    begin
        root_entry_t entry;
        if (rst_n)
        begin
            // Results first: a beat accepted on this edge can never answer
            // an input taken on the same edge.
            if (out_valid && out_ready)
            begin
                if (pending_roots.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result beat, got %0d", $realtime,
                                 hypotenuse);
                end
                else
                begin
                    entry = pending_roots.pop_front();
                    if (hypotenuse !== entry.root)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: a=%0d b=%0d expected %0d got %0d", $realtime,
                                     entry.leg_a, entry.leg_b, entry.root, hypotenuse);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                entry.leg_a = side_a;
                entry.leg_b = side_b;
                entry.root = hypot_floor(side_a, side_b);
                pending_roots.push_back(entry);
            end
            pending_count = pending_roots.size();
        end
    end

endmodule

// ----- tb/sv/integer_hypotenuse_sqrt_test.sv -----
// Top-level testbench for integer_hypotenuse_sqrt: drives leg pairs and the
// result handshake, and gives the verdict. Depends on ihs_pkg, the block and
// hypot_checker.
module integer_hypotenuse_sqrt_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LEG_WIDTH   = 16;
    localparam int          RANDOM_PAIRS = 1600;
    // The slowest correct run stays well under this limit: each beat can see a
    // sender gap, the root iteration and a result stall.
    localparam int          CYCLE_LIMIT = 1000000;
    // A little more than the block's latency.
    localparam int          SETTLE_CYCLES = 30;

    logic                             clk;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_ready;
    logic signed [LEG_WIDTH-1:0]      side_a;
    logic signed [LEG_WIDTH-1:0]      side_b;
    logic                             out_valid;
    logic                             out_ready;
    logic [ihs_pkg::OUT_WIDTH-1:0]    hypotenuse;

    int fail_count;
    int pending_count;
    int cycle_count;
    int stall_left;
    // While steady is set, neither side inserts idle cycles.
    bit steady;

    integer_hypotenuse_sqrt #(
        .LEG_WIDTH (LEG_WIDTH)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .side_a     (side_a),
        .side_b     (side_b),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hypotenuse (hypotenuse)
    );

    hypot_checker #(
        .LEG_WIDTH (LEG_WIDTH)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .side_a        (side_a),
        .side_b        (side_b),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .hypotenuse    (hypotenuse),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = ~clk;
    end

    // Hard stop in case the block hangs on either handshake.
    initial
    begin
        cycle_count = 0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Length of an idle stretch: mostly none or short, now and then long.
    function automatic int idle_length();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (steady || pick < 55)
            return 0;
        else if (pick < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Result side: out_ready drops for random stretches. Every assignment
    // happens on a falling edge, so the block sees a stable level at the
    // rising edge.
    initial
    begin
        out_ready = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 99) < 30)
                    stall_left = idle_length();
            end
        end
    end

    // One input beat. An optional gap comes first, with valid low; then valid
    // rises with the payload and holds until the beat is taken. Each falling
    // edge carries at most one assignment to in_valid.
    task automatic push_pair(input logic [LEG_WIDTH-1:0] leg_a,
                             input logic [LEG_WIDTH-1:0] leg_b);
        int gap;
        gap = idle_length();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        side_a <= leg_a;
        side_b <= leg_b;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Hold the sender off until every predicted root has come back.
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
    endtask

    // A random leg, weighted toward the interesting parts of the range: raw
    // 16-bit patterns, small magnitudes of either sign, values next to the
    // two extremes, and zero.
    function automatic logic [LEG_WIDTH-1:0] random_leg();
        int unsigned pick;
        logic [LEG_WIDTH-1:0] leg;
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            leg = LEG_WIDTH'($urandom);
        end
        else if (pick < 70)
        begin
            leg = LEG_WIDTH'($urandom_range(0, 300));
            if ($urandom_range(0, 1) == 1)
                leg = -leg;
        end
        else if (pick < 80)
        begin
            leg = {1'b0, {(LEG_WIDTH-1){1'b1}}} - LEG_WIDTH'($urandom_range(0, 3));
        end
        else if (pick < 90)
        begin
            leg = {1'b1, {(LEG_WIDTH-1){1'b0}}} + LEG_WIDTH'($urandom_range(0, 3));
        end
        else
        begin
            leg = '0;
        end
        return leg;
    endfunction

    initial
    begin
        logic [LEG_WIDTH-1:0] leg_a;
        logic [LEG_WIDTH-1:0] leg_b;
        int unsigned scale;

        in_valid = 1'b0;
        side_a = '0;
        side_b = '0;
        steady = 1'b0;

        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed pairs: zero, both extremes on each leg, the most negative
        // leg on both sides (a sum of squares of exactly 2^31), sign mixes,
        // perfect squares and alternating bit patterns.
        push_pair(16'sd0, 16'sd0);
        push_pair(16'sd32767, 16'sd32767);
        push_pair(-16'sd32768, -16'sd32768);
        push_pair(-16'sd32768, 16'sd0);
        push_pair(16'sd0, -16'sd32768);
        push_pair(16'sd32767, -16'sd32768);
        push_pair(-16'sd32767, -16'sd32767);
        push_pair(16'sd0, 16'sd32767);
        push_pair(-16'sd1, -16'sd1);
        push_pair(16'sd1, 16'sd0);
        push_pair(16'sd1, 16'sd1);
        push_pair(16'sd3, 16'sd4);
        push_pair(-16'sd3, 16'sd4);
        push_pair(16'sd5, -16'sd12);
        push_pair(16'sd19660, 16'sd26214);
        push_pair(16'h5555, 16'hAAAA);
        push_pair(16'hAAAA, 16'h5555);
        push_pair(16'sd2, 16'sd2);
        push_pair(16'sd181, 16'sd0);
        push_pair(-16'sd32768, 16'sd32767);

        // Let everything come back before the random part.
        drain_results();

        // Random pairs in blocks of 100; about one block in four runs with
        // no idling on either side, and every fourth block ends in a drain.
        for (int i = 0; i < RANDOM_PAIRS; i++)
        begin
            if (i % 100 == 0)
                steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0)
            begin
                // Scaled 3-4-5 triangles give exact roots.
                scale = $urandom_range(0, 6553);
                leg_a = LEG_WIDTH'(3 * scale);
                leg_b = LEG_WIDTH'(4 * scale);
                if ($urandom_range(0, 1) == 1)
                    leg_a = -leg_a;
                if ($urandom_range(0, 1) == 1)
                    leg_b = -leg_b;
            end
            else
            begin
                leg_a = random_leg();
                leg_b = random_leg();
            end
            push_pair(leg_a, leg_b);
            if (i % 400 == 399)
                drain_results();
        end

        // Wait for the last roots, then wait out SETTLE_CYCLES so that any stray
        // result beat is caught by the checker.
        steady = 1'b0;
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (fail_count == 0 && pending_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- integer_hypotenuse_sqrt.f -----
src/ihs_pkg.sv
src/ihs_root.sv
src/integer_hypotenuse_sqrt.sv
tb/sv/hypot_checker.sv
tb/sv/integer_hypotenuse_sqrt_test.sv
